// ----- rtl/htpc_pkg.sv -----
// Package for the hash table probe and chain block: sizes, status codes,
// the sequencer's state type and the structs between storage and control.
// No dependencies.
`default_nettype none

package htpc_pkg;

    // Number of table slots. Keep it a power of two (2 to 1024): the home
    // slot is then the low bits of the key.
    localparam int TABLE_SIZE = 16;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_W      = 31;
    localparam int OUT_SLOT_W = 4;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [KEY_W-1:0]  key_t;

    localparam cnt_t PROBE_LIMIT = CNT_W'(TABLE_SIZE);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0]
    {
        S_IDLE   = 6'b000001,
        S_HOME   = 6'b000010,
        S_WALK   = 6'b000100,
        S_FREE   = 6'b001000,
        S_SRCH   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    // One slot as seen by the sequencer
    typedef struct packed
    {
        logic  occupied;
        logic  link_valid;
        slot_t link;
        key_t  key;
    } slot_rd_t;

    // Store of a new key plus the link from the chain end
    typedef struct packed
    {
        logic  key_we;
        slot_t key_addr;
        key_t  key_data;
        logic  link_we;
        slot_t link_addr;
        slot_t link_data;
    } slot_wr_t;

    // Finished result of one request
    typedef struct packed
    {
        status_t                status;
        logic [OUT_SLOT_W-1:0]  slot;
    } result_t;

    // Low bits of a slot index as reported on the result beat
    function automatic logic [OUT_SLOT_W-1:0] report_slot(slot_t s);
        logic [OUT_SLOT_W+SLOT_W-1:0] wide;
        wide = {{OUT_SLOT_W{1'b0}}, s};
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/htpc_if.sv -----
// Handshake channels of the hash table block: request and result beats.
// Depends on htpc_pkg.
`default_nettype none

interface htpc_req_if import htpc_pkg::*;;
    logic valid;
    logic ready;
    logic op;
    key_t key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface htpc_rsp_if import htpc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

// ----- rtl/hash_table_probe_chain_insert_search.sv -----
// Hash table with linear probing and chaining without replacement, TABLE_SIZE
// slots. A request beat (op 0 insert, 1 search, plus a key) gives one result
// beat (status and slot). One probe pointer visits one slot per cycle
// through the home probe, the chain walk and the free slot probe. The next
// request is taken once the previous one is finished, while its result may
// still sit in the output register. No clearing pass follows reset.
`default_nettype none

module hash_table_probe_chain_insert_search import htpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    htpc_req_if.sink  req,
    htpc_rsp_if.source rsp
);

    logic     seq_idle;
    logic     res_valid;
    logic     res_free;
    result_t  res;
    slot_t    rd_addr;
    slot_rd_t rd;
    slot_wr_t wr;

    logic    rsp_valid_reg, rsp_valid_next;
    result_t rsp_data_reg;

    assign req.ready = seq_idle;
    assign res_free  = !rsp_valid_reg || rsp.ready;

    htpc_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid),
        .start_op  (req.op),
        .start_key (req.key),
        .idle      (seq_idle),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd        (rd),
        .wr        (wr)
    );

    htpc_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr      (wr)
    );

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_free)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
            rsp_data_reg <= res;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_data_reg.status;
    assign rsp.slot   = rsp_data_reg.slot;

endmodule

`default_nettype wire

// ----- rtl/htpc_store.sv -----
// Slot storage: keys, occupied flags, link-valid flags and next links.
// One read address per cycle, one key write and one link write. Uses htpc_pkg.
`default_nettype none

module htpc_store import htpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire slot_t    rd_addr,
    output slot_rd_t     rd,
    input  wire slot_wr_t wr
);

    logic [TABLE_SIZE-1:0] occupied_reg;
    logic [TABLE_SIZE-1:0] link_valid_reg;
    key_t                  keys_reg  [TABLE_SIZE];
    slot_t                 links_reg [TABLE_SIZE];

    // Flags: cleared by reset, set on writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg   <= '0;
            link_valid_reg <= '0;
        end
        else
        begin
            if (wr.key_we)
                occupied_reg[wr.key_addr] <= 1'b1;
            if (wr.link_we)
                link_valid_reg[wr.link_addr] <= 1'b1;
        end
    end

    // Payload: keys and link targets
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
            keys_reg[wr.key_addr] <= wr.key_data;
        if (wr.link_we)
            links_reg[wr.link_addr] <= wr.link_data;
    end

    // Read the slot under the probe pointer
    always_comb
    begin
        rd.occupied   = occupied_reg[rd_addr];
        rd.link_valid = link_valid_reg[rd_addr];
        rd.link       = links_reg[rd_addr];
        rd.key        = keys_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/htpc_seq.sv -----
// Sequencer: steps one probe pointer through home probe, chain walk, free
// slot probe and chain search, one slot per cycle. Uses htpc_pkg.
`default_nettype none

module htpc_seq import htpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     start_op,
    input  wire key_t     start_key,
    output logic          idle,
    input  wire logic     res_free,
    output logic          res_valid,
    output result_t       res,
    output slot_t         rd_addr,
    input  wire slot_rd_t rd,
    output slot_wr_t      wr
);

    state_t  state_reg, state_next;
    logic    op_reg, op_next;
    key_t    key_reg, key_next;
    slot_t   pos_reg, pos_next;
    slot_t   end_reg, end_next;
    cnt_t    cnt_reg, cnt_next;
    result_t res_reg, res_next;

    // Shared compare and step unit, working on the slot under the pointer
    logic  home_match;
    logic  key_match;
    logic  limit_hit;
    slot_t pos_step;
    cnt_t  cnt_step;

    assign home_match = rd.key[SLOT_W-1:0] == key_reg[SLOT_W-1:0];
    assign key_match  = rd.key == key_reg;
    assign limit_hit  = cnt_reg == PROBE_LIMIT;
    assign pos_step   = pos_reg + SLOT_W'(1);
    assign cnt_step   = cnt_reg + CNT_W'(1);

    assign rd_addr   = pos_reg;
    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_FINISH;
    assign res       = res_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        wr         = '0;
        wr.key_addr  = pos_reg;
        wr.key_data  = key_reg;
        wr.link_addr = end_reg;
        wr.link_data = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = start_op;
                    key_next   = start_key;
                    pos_next   = start_key[SLOT_W-1:0];
                    cnt_next   = '0;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                // Probe for a free slot or a chain of the same home
                if (limit_hit)
                begin
                    res_next.status = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    res_next.slot   = '0;
                    state_next      = S_FINISH;
                end
                else if (!rd.occupied || home_match)
                begin
                    cnt_next = '0;
                    if (op_reg == OP_INSERT)
                        state_next = S_WALK;
                    else if (!rd.occupied)
                    begin
                        res_next.status = ST_NOT_FOUND;
                        res_next.slot   = '0;
                        state_next      = S_FINISH;
                    end
                    else
                        state_next = S_SRCH;
                end
                else
                begin
                    pos_next = pos_step;
                    cnt_next = cnt_step;
                end
            end
            S_WALK:
            begin
                // Follow the chain to its end
                if (rd.link_valid && !limit_hit)
                begin
                    pos_next = rd.link;
                    cnt_next = cnt_step;
                end
                else
                begin
                    end_next   = pos_reg;
                    cnt_next   = '0;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                // Probe on to a free slot, then store and link
                if (rd.occupied && !limit_hit)
                begin
                    pos_next = pos_step;
                    cnt_next = cnt_step;
                end
                else if (limit_hit)
                begin
                    res_next.status = ST_FULL;
                    res_next.slot   = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    wr.key_we       = 1'b1;
                    wr.link_we      = pos_reg != end_reg;
                    res_next.status = ST_INSERTED;
                    res_next.slot   = report_slot(pos_reg);
                    state_next      = S_FINISH;
                end
            end
            S_SRCH:
            begin
                // Walk the chain looking for an equal key
                if (limit_hit)
                begin
                    res_next.status = ST_NOT_FOUND;
                    res_next.slot   = '0;
                    state_next      = S_FINISH;
                end
                else if (rd.occupied && key_match)
                begin
                    res_next.status = ST_FOUND;
                    res_next.slot   = report_slot(pos_reg);
                    state_next      = S_FINISH;
                end
                else if (!rd.link_valid)
                begin
                    res_next.status = ST_NOT_FOUND;
                    res_next.slot   = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    pos_next = rd.link;
                    cnt_next = cnt_step;
                end
            end
            S_FINISH:
            begin
                // Hold the result until the output register takes it
                if (res_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload of the request in flight
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        pos_reg <= pos_next;
        end_reg <= end_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- dv/hash_table_probe_chain_insert_search_tb.sv -----
`timescale 1ns / 100ps
// Testbench for hash_table_probe_chain_insert_search: drives insert and search
// beats, predicts every status and slot from a private copy of the table.
// Depends on htpc_pkg and the htpc_req_if / htpc_rsp_if interfaces.

module hash_table_probe_chain_insert_search_tb;
    import htpc_pkg::*;

    localparam int    RANDOM_ITEMS  = 1600;
    localparam int    CALM_TAIL     = 200;
    localparam int    LONG_HOLD     = 300;
    localparam int    HOLD_AFTER    = 300;
    localparam int    DRAIN_AT      = 800;
    localparam int    STALL_LIMIT   = 2000;
    localparam int    SETTLE_CYCLES = 3 * TABLE_SIZE + 10;
    // Home value that no insert uses until the table is full, so that a full
    // table later holds no chain for it
    localparam slot_t SPARE_HOME    = slot_t'(7);

    // One accepted request and the result it must produce
    typedef struct
    {
        op_t     op;
        key_t    key;
        result_t want;
    } request_rec_t;

    // Table copy, expected results and mismatch count
    class chain_table_scoreboard;
        key_t         slot_key[TABLE_SIZE];
        bit           slot_used[TABLE_SIZE];
        bit           slot_linked[TABLE_SIZE];
        slot_t        slot_next[TABLE_SIZE];
        int           used_count;
        int           mismatches;
        request_rec_t due_results[$];

        function new();
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_key[i]    = '0;
                slot_used[i]   = 1'b0;
                slot_linked[i] = 1'b0;
                slot_next[i]   = '0;
            end
            used_count = 0;
            mismatches = 0;
        endfunction

        function slot_t home_of(key_t k);
            return slot_t'(k % TABLE_SIZE);
        endfunction

        function slot_t step_of(slot_t s);
            return slot_t'((int'(s) + 1) % TABLE_SIZE);
        endfunction

        function bit is_full();
            return used_count == TABLE_SIZE;
        endfunction

        function key_t any_stored_key();
            int s;
            do
                s = $urandom_range(0, TABLE_SIZE - 1);
            while (!slot_used[s]);
            return slot_key[s];
        endfunction

        // Probe from the home slot for a free slot or one holding the same home
        function bit probe_home(key_t k, output slot_t at);
            slot_t p;
            int    n;
            p = home_of(k);
            n = 0;
            while (n < TABLE_SIZE && slot_used[p])
            begin
                if (home_of(slot_key[p]) == home_of(k))
                    break;
                n++;
                p = step_of(p);
            end
            at = p;
            return n < TABLE_SIZE;
        endfunction

        function result_t insert_key(key_t k);
            result_t r;
            slot_t   tail;
            slot_t   spot;
            int      n;
            r.status = ST_FULL;
            r.slot   = '0;
            if (!probe_home(k, tail))
                return r;
            // walk to the end of the chain
            n = 0;
            while (slot_linked[tail] && n < TABLE_SIZE)
            begin
                tail = slot_next[tail];
                n++;
            end
            // probe on for a free slot, counted separately
            spot = tail;
            n = 0;
            while (slot_used[spot] && n < TABLE_SIZE)
            begin
                spot = step_of(spot);
                n++;
            end
            if (n == TABLE_SIZE)
                return r;
            slot_key[spot]  = k;
            slot_used[spot] = 1'b1;
            used_count++;
            if (spot != tail)
            begin
                slot_next[tail]   = spot;
                slot_linked[tail] = 1'b1;
            end
            r.status = ST_INSERTED;
            r.slot   = OUT_SLOT_W'(spot);
            return r;
        endfunction

        function result_t search_key(key_t k);
            result_t r;
            slot_t   p;
            r.status = ST_NOT_FOUND;
            r.slot   = '0;
            if (!probe_home(k, p) || !slot_used[p])
                return r;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                if (slot_used[p] && slot_key[p] == k)
                begin
                    r.status = ST_FOUND;
                    r.slot   = OUT_SLOT_W'(p);
                    return r;
                end
                if (!slot_linked[p])
                    return r;
                p = slot_next[p];
            end
            return r;
        endfunction

        function void note_request(op_t op, key_t k);
            request_rec_t rec;
            rec.op   = op;
            rec.key  = k;
            rec.want = (op == OP_INSERT) ? insert_key(k) : search_key(k);
            due_results.push_back(rec);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_result(logic [1:0] status, logic [OUT_SLOT_W-1:0] slot);
            request_rec_t oldest;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result status %0d slot %0d with no request open",
                                          status, slot));
                return;
            end
            oldest = due_results.pop_front();
            if (status !== oldest.want.status)
                report_mismatch($sformatf("%s key %h: status %0d, expected %0d",
                                          oldest.op.name(), oldest.key, status,
                                          oldest.want.status));
            if (slot !== oldest.want.slot)
                report_mismatch($sformatf("%s key %h: slot %0d, expected %0d",
                                          oldest.op.name(), oldest.key, slot,
                                          oldest.want.slot));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   requests_taken;
    bit   tx_idling;
    bit   rx_idling;

    chain_table_scoreboard board;

    htpc_req_if req_ch();
    htpc_rsp_if rsp_ch();

    hash_table_probe_chain_insert_search DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build a key with the given home and upper bits that are random, small
    // or near the top of the range
    function automatic key_t key_with_home(slot_t h);
        key_t k;
        k = key_t'($urandom);
        if ($urandom_range(0, 3) == 0)
            k = key_t'($urandom_range(0, 3) * TABLE_SIZE);
        else if ($urandom_range(0, 7) == 0)
            k = ~key_t'($urandom_range(0, 3) * TABLE_SIZE);
        return key_t'(k - k % TABLE_SIZE + h);
    endfunction

    // Offer one request beat and hold it until taken
    task automatic send_request(op_t op, key_t k);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= k;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(op, k);
        requests_taken++;
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        if (tx_idling && $urandom_range(0, 9) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Pick and send one random request shaped by how full the table is
    task automatic random_request();
        op_t   op;
        key_t  k;
        slot_t h;
        if (!board.is_full())
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                op = OP_INSERT;
                if ($urandom_range(0, 9) == 0)
                    k = board.any_stored_key();
                else
                begin
                    // crowd a few homes to build chains and displaced slots
                    h = $urandom_range(0, 1) ? slot_t'($urandom_range(0, 2))
                                             : slot_t'($urandom_range(0, TABLE_SIZE - 1));
                    if (h == SPARE_HOME)
                        h = h + 1'b1;
                    k = key_with_home(h);
                end
            end
            else
            begin
                op = OP_SEARCH;
                k = $urandom_range(0, 1) ? board.any_stored_key()
                                         : key_with_home(slot_t'($urandom_range(0, TABLE_SIZE - 1)));
            end
        end
        else
        begin
            op = ($urandom_range(0, 4) == 0) ? OP_INSERT : OP_SEARCH;
            if ($urandom_range(0, 1))
                k = board.any_stored_key();
            else if ($urandom_range(0, 3) == 0)
                k = key_with_home(SPARE_HOME);
            else
                k = key_with_home(slot_t'($urandom_range(0, TABLE_SIZE - 1)));
        end
        send_request(op, k);
    endtask

    // Result side: check beats, stall in bursts, one long hold-off
    initial
    begin
        int hold_left;
        int stall_left;
        bit held_once;
        hold_left  = 0;
        stall_left = 0;
        held_once  = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.status, rsp_ch.slot);
            if (!held_once && requests_taken >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run after too many cycles with no beat taken
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus: reset, directed requests, random requests, drain
    initial
    begin
        board          = new();
        requests_taken = 0;
        tx_idling      = 1'b1;
        rx_idling      = 1'b1;
        req_ch.valid   = 1'b0;
        req_ch.op      = 1'b0;
        req_ch.key     = '0;
        rst_n          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the key on an empty table
        send_request(OP_SEARCH, 31'h0000_0000);
        send_request(OP_INSERT, 31'h0000_0000);
        send_request(OP_INSERT, 31'h7FFF_FFFF);
        send_request(OP_SEARCH, 31'h0000_0000);
        send_request(OP_SEARCH, 31'h7FFF_FFFF);
        // same home present but key absent, then an empty home slot
        send_request(OP_SEARCH, 31'h0000_0010);
        send_request(OP_SEARCH, 31'h0000_0003);
        // chain on home 0, then a duplicate insert appended to it
        send_request(OP_INSERT, 31'h0000_0010);
        send_request(OP_INSERT, 31'h0000_0000);
        send_request(OP_SEARCH, 31'h0000_0000);
        send_request(OP_SEARCH, 31'h0000_0010);
        // home slot taken by another home: probe past it
        send_request(OP_INSERT, 31'h0000_0001);
        send_request(OP_SEARCH, 31'h0000_0001);
        // chain from the top slot wraps around to the bottom
        send_request(OP_INSERT, 31'h7FFF_FFEF);
        send_request(OP_SEARCH, 31'h7FFF_FFEF);
        // alternating bit patterns
        send_request(OP_INSERT, 31'h2AAA_AAAA);
        send_request(OP_INSERT, 31'h5555_5555);
        send_request(OP_SEARCH, 31'h2AAA_AAAA);
        send_request(OP_SEARCH, 31'h5555_5557);
        send_request(OP_SEARCH, 31'h5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            tx_idling = (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 100) % 3 != 1);
            rx_idling = (i < RANDOM_ITEMS - CALM_TAIL) && ((i / 100) % 4 != 2);
            if (i == DRAIN_AT)
            begin
                // hold off until every outstanding result is back
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (board.due_results.size() != 0);
            end
            else
                sender_gap();
            random_request();
        end

        req_ch.valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
